/* src/wtf_pkg.sv */
// shared types, codes and constants of the write-track format parser
`timescale 1ns / 1ps
package wtf_pkg;

  // sector id store
  localparam int unsigned SlotCount = 32;
  localparam int unsigned PtrW      = $clog2(SlotCount + 1);
  localparam int unsigned AddrW     = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  // counters
  localparam int unsigned CntW = 17;
  localparam int unsigned LenW = 16;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] RegTrack = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSide  = 1'b1;

  // marks in the byte stream
  localparam logic [7:0] MarkIndex = 8'hFC;
  localparam logic [7:0] MarkId    = 8'hFE;
  localparam logic [7:0] MarkData  = 8'hFB;
  localparam logic [7:0] MarkDel   = 8'hF8;

  // byte timeouts, id field byte positions and the geometry limit
  localparam int unsigned MarkTimeout = 100;
  localparam int unsigned GapTimeout  = 200;
  localparam int unsigned IdSectorPos = 3;
  localparam int unsigned IdSizePos   = 4;
  localparam int unsigned GeoLimit    = 254;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_REJECT    = 4'd1,
    EV_ACCEPT    = 4'd2,
    EV_TIMEOUT   = 4'd3,
    EV_INDEX     = 4'd4,
    EV_INDEX_HDR = 4'd5,
    EV_ID        = 4'd6,
    EV_DMARK     = 4'd7,
    EV_SUMMARY   = 4'd8,
    EV_SECTOR    = 4'd9
  } event_e;

  typedef enum logic [1:0] {
    STAT_IDLE      = 2'd0,
    STAT_BUSY      = 2'd1,
    STAT_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    STG_INDEX  = 3'd0,
    STG_ID     = 3'd1,
    STG_HEADER = 3'd2,
    STG_DATA   = 3'd3,
    STG_GAP    = 3'd4,
    STG_DONE   = 3'd5
  } stage_e;

  typedef struct packed {
    logic [7:0] track;
    logic       side;
  } cfg_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [1:0] status;
    logic       irq_raised;
    logic [2:0] stage;
    logic [7:0] size_blocks;
    logic [7:0] sector_count;
    logic [7:0] fill_pattern;
    logic [7:0] sector_id;
    logic       geometry_ok;
    logic       last;
  } out_item_t;

endpackage

/* src/wtf_in_if.sv */
// input channel of the write-track format parser
`timescale 1ns / 1ps
interface wtf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic       drive_ready;
  logic       write_protected;

  modport source (output valid, command, data_byte, drive_ready, write_protected,
                  input ready);
  modport sink (input valid, command, data_byte, drive_ready, write_protected,
                output ready);
endinterface

/* src/wtf_out_if.sv */
// result channel of the write-track format parser
`timescale 1ns / 1ps
interface wtf_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [1:0] status;
  logic       irq_raised;
  logic [2:0] stage;
  logic [7:0] size_blocks;
  logic [7:0] sector_count;
  logic [7:0] fill_pattern;
  logic [7:0] sector_id;
  logic       geometry_ok;
  logic       last;

  modport source (output valid, event_res, status, irq_raised, stage, size_blocks,
                  sector_count, fill_pattern, sector_id, geometry_ok, last,
                  input ready);
  modport sink (input valid, event_res, status, irq_raised, stage, size_blocks,
                sector_count, fill_pattern, sector_id, geometry_ok, last,
                output ready);
endinterface

/* src/wtf_id_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
module wtf_id_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/wtf_core.sv */
// byte-stream parser, result register and sector id read-out sequencer
`timescale 1ns / 1ps
module wtf_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wtf_pkg::cfg_t                 cfg_i,
  wtf_in_if.sink                        in_i,
  wtf_out_if.source                     out_o,
  output logic                          ram_we_o,
  output logic [wtf_pkg::AddrW-1:0]     ram_waddr_o,
  output logic [7:0]                    ram_wdata_o,
  output logic                          ram_re_o,
  output logic [wtf_pkg::AddrW-1:0]     ram_raddr_o,
  input  logic [7:0]                    ram_rdata_i
);

  typedef enum logic {
    DUMP_IDLE = 1'b0,
    DUMP_RUN  = 1'b1
  } dump_e;

  wtf_pkg::stage_e          stage_q, stage_d;
  wtf_pkg::status_e         status_q, status_d;
  logic [wtf_pkg::CntW-1:0] count_q, count_d;
  logic [wtf_pkg::LenW-1:0] len_q, len_d;
  logic [7:0]               size_q, size_d;
  logic [7:0]               total_q, total_d;
  logic [7:0]               fill_q, fill_d;
  logic [wtf_pkg::PtrW-1:0] ptr_q, ptr_d;
  dump_e                    dump_q, dump_d;
  logic [wtf_pkg::PtrW-1:0] didx_q, didx_d;
  logic [wtf_pkg::PtrW-1:0] dn_q, dn_d;
  logic                     ov_q, ov_d;
  wtf_pkg::out_item_t       oitem_q, oitem_d;

  logic slot_free, take, track_end, dump_load, dump_last;
  logic [15:0] geo_prod;
  logic        geo_ok;

  assign slot_free = !ov_q || out_o.ready;
  assign in_i.ready = (dump_q == DUMP_IDLE) && slot_free;
  assign take = in_i.valid && in_i.ready;
  assign dump_load = (dump_q == DUMP_RUN) && slot_free;
  assign dump_last = ((didx_q + 1'b1) == dn_q);

  assign geo_prod = total_q * size_q;
  assign geo_ok = (total_q != 8'd0) && (size_q != 8'd0) &&
                  (geo_prod <= 16'(wtf_pkg::GeoLimit));

  always_comb begin
    wtf_pkg::event_e ev;
    logic            irq;
    logic            adv;
    logic            do_abort;
    stage_d   = stage_q;
    status_d  = status_q;
    count_d   = count_q;
    len_d     = len_q;
    size_d    = size_q;
    total_d   = total_q;
    fill_d    = fill_q;
    ptr_d     = ptr_q;
    dump_d    = dump_q;
    didx_d    = didx_q;
    dn_d      = dn_q;
    ov_d      = ov_q;
    oitem_d   = oitem_q;
    ev        = wtf_pkg::EV_NONE;
    irq       = 1'b0;
    adv       = 1'b0;
    do_abort  = 1'b0;
    track_end = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = ptr_q[wtf_pkg::AddrW-1:0];
    ram_wdata_o = in_i.data_byte;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    if (take) begin
      if (!in_i.command) begin
        len_d = '0;
        ptr_d = '0;
        if (!in_i.drive_ready || in_i.write_protected) begin
          status_d = wtf_pkg::STAT_NOT_READY;
          ev  = wtf_pkg::EV_REJECT;
          irq = 1'b1;
        end else begin
          stage_d  = wtf_pkg::STG_INDEX;
          count_d  = '0;
          status_d = wtf_pkg::STAT_BUSY;
          ev = wtf_pkg::EV_ACCEPT;
        end
      end else begin
        adv = 1'b1;
        case (stage_q)
          wtf_pkg::STG_INDEX: begin
            if (in_i.data_byte == wtf_pkg::MarkIndex) begin
              stage_d = wtf_pkg::STG_ID;
              count_d = '0;
              size_d  = '0;
              total_d = '0;
              fill_d  = '0;
              ptr_d   = '0;
              ev = (cfg_i.track == 8'd0 && !cfg_i.side && !in_i.write_protected) ?
                   wtf_pkg::EV_INDEX_HDR : wtf_pkg::EV_INDEX;
            end else if (count_q > wtf_pkg::CntW'(wtf_pkg::MarkTimeout)) begin
              do_abort = 1'b1;
            end
          end
          wtf_pkg::STG_ID: begin
            if (in_i.data_byte == wtf_pkg::MarkId) begin
              stage_d = wtf_pkg::STG_HEADER;
              count_d = '0;
              total_d = 8'd1;
              ptr_d   = '0;
              ev = wtf_pkg::EV_ID;
            end else if (count_q > wtf_pkg::CntW'(wtf_pkg::MarkTimeout)) begin
              do_abort = 1'b1;
            end
          end
          wtf_pkg::STG_HEADER: begin
            if (count_q <= wtf_pkg::CntW'(wtf_pkg::IdSizePos)) begin
              if (count_q == wtf_pkg::CntW'(wtf_pkg::IdSectorPos)) begin
                if (ptr_q < wtf_pkg::PtrW'(wtf_pkg::SlotCount)) begin
                  ram_we_o = 1'b1;
                  ptr_d = ptr_q + 1'b1;
                end
              end else if (count_q == wtf_pkg::CntW'(wtf_pkg::IdSizePos)) begin
                size_d = in_i.data_byte;
              end
            end else if (in_i.data_byte == wtf_pkg::MarkData ||
                         in_i.data_byte == wtf_pkg::MarkDel) begin
              stage_d = wtf_pkg::STG_DATA;
              count_d = '0;
              len_d   = {size_q, 8'h00};
              ev = wtf_pkg::EV_DMARK;
            end else if (count_q > wtf_pkg::CntW'(wtf_pkg::MarkTimeout)) begin
              do_abort = 1'b1;
            end
          end
          wtf_pkg::STG_DATA: begin
            if (count_q == wtf_pkg::CntW'(1)) begin
              fill_d = in_i.data_byte;
            end
            if (count_q > {1'b0, len_q}) begin
              stage_d = wtf_pkg::STG_GAP;
              count_d = '0;
              len_d   = '0;
            end
          end
          wtf_pkg::STG_GAP: begin
            if (in_i.data_byte == wtf_pkg::MarkId) begin
              stage_d = wtf_pkg::STG_HEADER;
              count_d = '0;
              total_d = total_q + 8'd1;
              ev = wtf_pkg::EV_ID;
            end else if (count_q > wtf_pkg::CntW'(wtf_pkg::GapTimeout)) begin
              track_end = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (do_abort || track_end) begin
          adv      = 1'b0;
          status_d = wtf_pkg::STAT_IDLE;
          stage_d  = wtf_pkg::STG_DONE;
          irq      = 1'b1;
          ev       = do_abort ? wtf_pkg::EV_TIMEOUT : wtf_pkg::EV_SUMMARY;
        end
      end

      if (adv) begin
        count_d = count_d + 1'b1;
      end

      ov_d = 1'b1;
      oitem_d = '0;
      oitem_d.event_res  = ev;
      oitem_d.status     = status_d;
      oitem_d.irq_raised = irq;
      oitem_d.stage      = stage_d;
      oitem_d.last       = 1'b1;
      if (track_end) begin
        oitem_d.size_blocks  = size_q;
        oitem_d.sector_count = total_q;
        oitem_d.fill_pattern = fill_q;
        oitem_d.geometry_ok  = geo_ok;
        if (ptr_q != '0) begin
          // stored ids follow: fetch the first one now
          oitem_d.last = 1'b0;
          dump_d   = DUMP_RUN;
          didx_d   = '0;
          dn_d     = ptr_q;
          ram_re_o = 1'b1;
        end
      end
    end else if (dump_load) begin
      ov_d = 1'b1;
      oitem_d = '0;
      oitem_d.event_res = wtf_pkg::EV_SECTOR;
      oitem_d.status    = status_q;
      oitem_d.stage     = stage_q;
      oitem_d.sector_id = ram_rdata_i;
      oitem_d.last      = dump_last;
      if (dump_last) begin
        dump_d = DUMP_IDLE;
      end else begin
        didx_d      = didx_q + 1'b1;
        ram_re_o    = 1'b1;
        ram_raddr_o = didx_d[wtf_pkg::AddrW-1:0];
      end
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= wtf_pkg::STG_DONE;
      status_q <= wtf_pkg::STAT_IDLE;
      count_q  <= '0;
      len_q    <= '0;
      size_q   <= '0;
      total_q  <= '0;
      fill_q   <= '0;
      ptr_q    <= '0;
      dump_q   <= DUMP_IDLE;
      didx_q   <= '0;
      dn_q     <= '0;
      ov_q     <= 1'b0;
    end else begin
      stage_q  <= stage_d;
      status_q <= status_d;
      count_q  <= count_d;
      len_q    <= len_d;
      size_q   <= size_d;
      total_q  <= total_d;
      fill_q   <= fill_d;
      ptr_q    <= ptr_d;
      dump_q   <= dump_d;
      didx_q   <= didx_d;
      dn_q     <= dn_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oitem_q <= oitem_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.event_res    = oitem_q.event_res;
  assign out_o.status       = oitem_q.status;
  assign out_o.irq_raised   = oitem_q.irq_raised;
  assign out_o.stage        = oitem_q.stage;
  assign out_o.size_blocks  = oitem_q.size_blocks;
  assign out_o.sector_count = oitem_q.sector_count;
  assign out_o.fill_pattern = oitem_q.fill_pattern;
  assign out_o.sector_id    = oitem_q.sector_id;
  assign out_o.geometry_ok  = oitem_q.geometry_ok;
  assign out_o.last         = oitem_q.last;

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= wtf_pkg::PtrW'(wtf_pkg::SlotCount))
    else $error("id write pointer beyond store");

  a_dump_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump_q == DUMP_RUN) |-> (didx_q < dn_q))
    else $error("read-out index past stored count");

  a_summary_starts_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && track_end && ptr_q != '0) |=>
      (dump_q == DUMP_RUN && ov_q && !oitem_q.last))
    else $error("summary with stored ids did not start read-out");

  a_dump_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dump_load && dump_last) |=> (dump_q == DUMP_IDLE && oitem_q.last))
    else $error("read-out did not end with last item");

endmodule

/* src/write_track_format_parser_unit.sv */
// top level of the write-track format parser: config registers, parser core, id store
// result: a result item appears in the output register in the cycle after its item is accepted
// throughput: one item per cycle while the result side takes every item
// track end: summary item, then one stored sector id per cycle from the id ram unless stalled
//   (1 + n items); no new item is accepted until the last sector id has been loaded
// reset: asynchronous active low, clears parser state and config; id ram is not cleared
`timescale 1ns / 1ps
module write_track_format_parser_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wtf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [wtf_pkg::CfgDataW-1:0]   cfg_data_i,
  wtf_in_if.sink                         in_i,
  wtf_out_if.source                      out_o
);

  // config registers; the user must write them only while idle, the block does not enforce it
  logic [7:0] track_q;
  logic       side_q;
  wtf_pkg::cfg_t cfg;

  // id ram port signals
  logic                      ram_we, ram_re;
  logic [wtf_pkg::AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]                ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= '0;
      side_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wtf_pkg::RegTrack: track_q <= cfg_data_i[7:0];
        wtf_pkg::RegSide:  side_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.track = track_q;
  assign cfg.side  = side_q;

  // parser, result register and read-out sequencer
  wtf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // sector id store, one entry per id slot
  wtf_id_ram #(
    .Depth (wtf_pkg::SlotCount),
    .Width (8),
    .AddrW (wtf_pkg::AddrW)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* verif/tb.sv */
// self-checking testbench for the write-track format parser unit
`timescale 1ns / 1ps
module tb;
  import wtf_pkg::*;

  // usual fillers of a format stream
  localparam logic [7:0] GapFill    = 8'h4E;
  localparam logic [7:0] FormatFill = 8'hE5;

  // input items offered over the whole run
  localparam int unsigned ItemBudget = 380;

  // one item offered on the input channel
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       drive_ready;
    logic       write_protected;
  } wr_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  wtf_in_if  in_ch ();
  wtf_out_if out_ch ();

  write_track_format_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // stimulus and expectation stores
  wr_item_t    byte_stream [$];
  out_item_t   due_events [$];
  wr_item_t    drv_item;

  // handshake bookkeeping between driver and monitor
  int unsigned n_sent, n_taken, n_queued, gap_left, stall_left, hold_left;
  int unsigned holds_asked, holds_served;
  bit          src_calm, sink_calm;

  // tallies for the closing report
  int unsigned n_bad, n_checked, n_rejects, n_timeouts, n_hdr, n_summaries;
  int unsigned n_geo_ok, n_ids, tracks_built, n_phases;

  // parser shadow: state and configuration as the block should hold them
  stage_e             p_stage;
  status_e            p_stat;
  logic [CntW-1:0]    p_cnt;
  logic [LenW-1:0]    p_len;
  logic [7:0]         p_size, p_total, p_fill;
  logic [7:0]         p_ids [SlotCount];
  logic [PtrW-1:0]    p_ptr;
  logic [7:0]         p_track;
  logic               p_side;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // shadow parser
  // ---------------------------------------------------------------------------

  // single result item, everything but the common fields zero
  task automatic post(input event_e ev, input logic irq);
    out_item_t it;
    it = '0;
    it.event_res  = ev;
    it.status     = p_stat;
    it.irq_raised = irq;
    it.stage      = p_stage;
    it.last       = 1'b1;
    due_events.push_back(it);
  endtask

  // lost mark: give up on the command
  task automatic abort_track();
    p_stat  = STAT_IDLE;
    p_stage = STG_DONE;
    post(EV_TIMEOUT, 1'b1);
    n_timeouts++;
  endtask

  // end of track: summary, then every stored sector number in order
  task automatic close_track();
    out_item_t   it;
    int          prod;
    int unsigned n;
    prod    = int'(p_total) * int'(p_size);
    n       = p_ptr;
    p_stat  = STAT_IDLE;
    p_stage = STG_DONE;
    it = '0;
    it.event_res    = EV_SUMMARY;
    it.status       = p_stat;
    it.irq_raised   = 1'b1;
    it.stage        = p_stage;
    it.size_blocks  = p_size;
    it.sector_count = p_total;
    it.fill_pattern = p_fill;
    it.geometry_ok  = (p_total != 0) && (p_size != 0) && (prod <= GeoLimit);
    it.last         = (n == 0);
    due_events.push_back(it);
    n_summaries++;
    if (it.geometry_ok) n_geo_ok++;
    for (int i = 0; i < n; i++) begin
      it = '0;
      it.event_res = EV_SECTOR;
      it.status    = p_stat;
      it.stage     = p_stage;
      it.sector_id = p_ids[AddrW'(i)];
      it.last      = (i + 1 == n);
      due_events.push_back(it);
    end
    n_ids += n;
  endtask

  // expected results of one accepted item
  task automatic format_step(input logic cmd, input logic [7:0] b, input logic rdy,
                             input logic wp);
    event_e ev;
    bit     ended;
    ev    = EV_NONE;
    ended = 1'b0;
    if (cmd == 1'b0) begin
      // start command: always forgets the data length and the stored ids
      p_len = '0;
      p_ptr = '0;
      if (!rdy || wp) begin
        p_stat = STAT_NOT_READY;
        post(EV_REJECT, 1'b1);
        n_rejects++;
      end else begin
        p_stage = STG_INDEX;
        p_cnt   = '0;
        p_stat  = STAT_BUSY;
        post(EV_ACCEPT, 1'b0);
      end
    end else begin
      case (p_stage)
        STG_INDEX: begin
          if (b == MarkIndex) begin
            p_stage = STG_ID;
            p_cnt   = '0;
            p_size  = '0;
            p_total = '0;
            p_fill  = '0;
            p_ptr   = '0;
            // header init only on track 0, side 0 of a writable disk
            if (p_track == 0 && p_side == 1'b0 && !wp) begin
              ev = EV_INDEX_HDR;
              n_hdr++;
            end else begin
              ev = EV_INDEX;
            end
          end else if (p_cnt > MarkTimeout) begin
            abort_track();
            ended = 1'b1;
          end
        end
        STG_ID: begin
          if (b == MarkId) begin
            p_stage = STG_HEADER;
            p_cnt   = '0;
            p_total = 8'd1;
            p_ptr   = '0;
            ev      = EV_ID;
          end else if (p_cnt > MarkTimeout) begin
            abort_track();
            ended = 1'b1;
          end
        end
        STG_HEADER: begin
          // four id bytes first, whatever their value, then wait for a data mark
          if (p_cnt <= IdSizePos) begin
            if (p_cnt == IdSectorPos) begin
              if (p_ptr < SlotCount) begin
                p_ids[p_ptr[AddrW-1:0]] = b;
                p_ptr                   = p_ptr + 1'b1;
              end
            end else if (p_cnt == IdSizePos) begin
              p_size = b;
            end
          end else if (b == MarkData || b == MarkDel) begin
            p_stage = STG_DATA;
            p_cnt   = '0;
            p_len   = {p_size, 8'h00};
            ev      = EV_DMARK;
          end else if (p_cnt > MarkTimeout) begin
            abort_track();
            ended = 1'b1;
          end
        end
        STG_DATA: begin
          if (p_cnt == 1) p_fill = b;
          if (p_cnt > p_len) begin
            p_stage = STG_GAP;
            p_cnt   = '0;
            p_len   = '0;
          end
        end
        STG_GAP: begin
          if (b == MarkId) begin
            p_stage = STG_HEADER;
            p_cnt   = '0;
            p_total = p_total + 1'b1;
            ev      = EV_ID;
          end else if (p_cnt > GapTimeout) begin
            close_track();
            ended = 1'b1;
          end
        end
        default: begin
          // finished: byte is ignored, counter still runs
        end
      endcase
      if (!ended) begin
        p_cnt = p_cnt + 1'b1;
        post(ev, 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic string show(input out_item_t it);
    return {$sformatf("ev=%0d st=%0d irq=%0d stg=%0d size=%0d cnt=%0d ",
                      it.event_res, it.status, it.irq_raised, it.stage, it.size_blocks,
                      it.sector_count),
            $sformatf("fill=%02h id=%02h geo=%0d last=%0d",
                      it.fill_pattern, it.sector_id, it.geometry_ok, it.last)};
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    string     bad;
    n_checked++;
    if (due_events.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("result with nothing expected: %s", show(got));
    end else begin
      want = due_events.pop_front();
      bad  = "";
      if (got.event_res !== want.event_res)       bad = {bad, " event_res"};
      if (got.status !== want.status)             bad = {bad, " status"};
      if (got.irq_raised !== want.irq_raised)     bad = {bad, " irq_raised"};
      if (got.stage !== want.stage)               bad = {bad, " stage"};
      if (got.size_blocks !== want.size_blocks)   bad = {bad, " size_blocks"};
      if (got.sector_count !== want.sector_count) bad = {bad, " sector_count"};
      if (got.fill_pattern !== want.fill_pattern) bad = {bad, " fill_pattern"};
      if (got.sector_id !== want.sector_id)       bad = {bad, " sector_id"};
      if (got.geometry_ok !== want.geometry_ok)   bad = {bad, " geometry_ok"};
      if (got.last !== want.last)                 bad = {bad, " last"};
      if (bad != "") begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("mismatch in%s", bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, now and then a long one
  function automatic int unsigned pause_len(input bit calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // input side: hold an offered item until taken, then a random gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && n_sent != n_taken) begin
      // still on offer
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (byte_stream.size() > 0) begin
      drv_item = byte_stream.pop_front();
      in_ch.command         <= drv_item.command;
      in_ch.data_byte       <= drv_item.data_byte;
      in_ch.drive_ready     <= drv_item.drive_ready;
      in_ch.write_protected <= drv_item.write_protected;
      in_ch.valid           <= 1'b1;
      n_sent++;
      gap_left = pause_len(src_calm);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result side: random stalls, plus a long hold-off on request to fill the block
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (holds_asked != holds_served) begin
      holds_served++;
      hold_left = 300;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pause_len(sink_calm);
    end
  end

  // both handshakes sampled at the rising edge; results before new predictions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        check_result({out_ch.event_res, out_ch.status, out_ch.irq_raised, out_ch.stage,
                      out_ch.size_blocks, out_ch.sector_count, out_ch.fill_pattern,
                      out_ch.sector_id, out_ch.geometry_ok, out_ch.last});
      end
      if (in_ch.valid && in_ch.ready) begin
        n_taken++;
        format_step(in_ch.command, in_ch.data_byte, in_ch.drive_ready,
                    in_ch.write_protected);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_raw(input logic cmd, input logic [7:0] b, input logic rdy,
                         input logic wp);
    byte_stream.push_back('{command: cmd, data_byte: b, drive_ready: rdy,
                            write_protected: wp});
    n_queued++;
  endtask

  task automatic add_start(input logic rdy, input logic wp);
    add_raw(1'b0, 8'($urandom), rdy, wp);
  endtask

  // data byte; the drive lines are don't-care here except for the index mark
  task automatic add_byte(input logic [7:0] b);
    add_raw(1'b1, b, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  function automatic logic [7:0] pick_mark();
    case ($urandom_range(3))
      0:       return MarkIndex;
      1:       return MarkId;
      2:       return MarkData;
      default: return MarkDel;
    endcase
  endfunction

  // filler bytes that carry none of the marks
  task automatic add_plain(input int unsigned n);
    logic [7:0] v;
    repeat (n) begin
      v = ($urandom_range(2) == 0) ? GapFill : 8'($urandom);
      while (v == MarkIndex || v == MarkId || v == MarkData || v == MarkDel) begin
        v = 8'($urandom);
      end
      add_byte(v);
    end
  endtask

  // id field, data mark and the whole data field of one sector
  task automatic add_sector(input logic [7:0] sec, input logic [7:0] sz);
    int unsigned span;
    span = 256 * int'(sz);
    add_byte(MarkId);
    add_byte(8'($urandom));
    add_byte(8'($urandom_range(1)));
    add_byte(sec);
    add_byte(sz);
    add_plain($urandom_range(4));
    add_byte(($urandom_range(3) == 0) ? MarkDel : MarkData);
    add_byte(8'($urandom));
    repeat (span) add_byte(($urandom_range(3) == 0) ? 8'($urandom) : FormatFill);
  endtask

  // complete track of short sectors, closed by running past the gap limit
  task automatic add_track(input int unsigned nsec);
    logic [7:0] sec;
    add_start(1'b1, 1'b0);
    add_plain($urandom_range(6));
    add_byte(MarkIndex);
    add_plain($urandom_range(6));
    for (int i = 0; i < nsec; i++) begin
      sec = 8'(i + 1);
      if ($urandom_range(4) == 0) sec = 8'($urandom);
      add_sector(sec, 8'd0);
      add_plain($urandom_range(4));
    end
    // one byte past the gap limit ends the track
    add_plain(GapTimeout + 1);
    tracks_built++;
  endtask

  // mark never comes: index, id or data mark wait
  task automatic add_lost_mark(input int unsigned k);
    add_start(1'b1, 1'b0);
    if (k > 0) add_byte(MarkIndex);
    if (k == 2) begin
      add_byte(MarkId);
      add_plain(4);
    end
    add_plain(MarkTimeout + 2 + $urandom_range(3));
  endtask

  // noise with marks in odd places and stray start commands, at most left items
  task automatic add_noise(input int unsigned left);
    int unsigned k, n;
    n = $urandom_range(30);
    if (n + 1 > left) n = (left > 0) ? left - 1 : 0;
    add_start(1'b1, 1'b0);
    repeat (n) begin
      k = $urandom_range(19);
      if (k < 6)       add_byte(pick_mark());
      else if (k == 6) add_start(1'($urandom_range(1)), 1'($urandom_range(1)));
      else             add_byte(8'($urandom));
    end
  endtask

  // register write while the block is idle
  task automatic program_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegTrack) p_track = v;
    else                 p_side  = v[0];
  endtask

  // wait for every item to go in and every result to come back
  task automatic settle();
    while (byte_stream.size() != 0 || n_sent != n_taken || due_events.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned spins;
    logic [7:0]  trk;
    logic        sd;

    // everything known from time zero
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = RegTrack;
    cfg_data_i            = '0;
    in_ch.valid           = 1'b0;
    in_ch.command         = 1'b0;
    in_ch.data_byte       = '0;
    in_ch.drive_ready     = 1'b0;
    in_ch.write_protected = 1'b0;
    out_ch.ready          = 1'b0;
    src_calm              = 1'b0;
    sink_calm             = 1'b0;

    // shadow state after reset
    p_stage = STG_DONE;
    p_stat  = STAT_IDLE;
    p_cnt   = '0;
    p_len   = '0;
    p_size  = '0;
    p_total = '0;
    p_fill  = '0;
    p_ptr   = '0;
    p_track = '0;
    p_side  = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    program_reg(RegTrack, 8'd0);
    program_reg(RegSide, 8'd0);

    // directed: ignored bytes, every refusal, header init, marks out of place
    add_byte(8'h00);
    add_byte(8'hFF);
    add_start(1'b0, 1'b0);
    add_start(1'b1, 1'b1);
    add_start(1'b0, 1'b1);
    add_start(1'b1, 1'b0);
    add_raw(1'b1, MarkIndex, 1'b1, 1'b0);
    add_byte(MarkIndex);
    add_byte(MarkId);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(MarkId);
    add_byte(MarkDel);
    add_byte(8'hA5);
    add_byte(MarkData);
    add_byte(MarkId);
    add_byte(8'h7F);
    add_byte(8'h80);
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte(MarkData);
    settle();

    // formatted track with stored ids, read out under a long result hold-off
    program_reg(RegTrack, 8'd255);
    program_reg(RegSide, {7'($urandom), 1'b1});
    add_track($urandom_range(3, 5));
    holds_asked++;
    settle();
    n_phases++;

    // a mark that never comes
    program_reg(RegTrack, 8'd0);
    program_reg(RegSide, 8'd1);
    add_lost_mark($urandom_range(2));
    settle();
    n_phases++;

    // noise phases until the item budget is used, each under its own register setting
    while (n_queued < ItemBudget) begin
      trk = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom);
      sd  = 1'($urandom_range(1));
      program_reg(RegTrack, trk);
      // upper data bits of the side register are don't-care
      program_reg(RegSide, {7'($urandom), sd});
      src_calm  = (n_phases % 3 == 2);
      sink_calm = (n_phases % 4 == 3);
      add_noise(ItemBudget - n_queued);
      settle();
      n_phases++;
    end

    // drain, bounded
    spins = 0;
    while ((byte_stream.size() != 0 || n_sent != n_taken || due_events.size() != 0) &&
           spins < 200000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (10) @(posedge clk_i);
    if (due_events.size() != 0) begin
      $display("%0d expected result items never arrived", due_events.size());
      n_bad += due_events.size();
    end

    $display("ran %0d items over %0d phases: %0d refused starts, %0d mark timeouts, %0d %s",
             n_taken, n_phases, n_rejects, n_timeouts, n_hdr, "header-init index marks");
    $display("%0d track ends (%0d fitting) read out %0d sector ids; %0d results checked",
             n_summaries, n_geo_ok, n_ids, n_checked);
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d bad result items", n_bad);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
src/wtf_pkg.sv
src/wtf_in_if.sv
src/wtf_out_if.sv
src/wtf_id_ram.sv
src/wtf_core.sv
src/write_track_format_parser_unit.sv
verif/tb.sv
